// ===== hdl/rfo_pkg.sv =====
// Shared types, widths and helpers for the ring FIFO with overwrite and peek.
// No dependencies; used by the top level, the slot RAM users and the checker.
`default_nettype none
package rfo_pkg;

  localparam int DEPTH     = 16;
  localparam int ELEM_BITS = 32;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int CFG_W  = 5;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 4;
  localparam int OP_W   = 2;

  // in_tdata: data_in, force_req
  localparam int IN_BITS     = DATA_W + 1;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_FORCE_LSB = DATA_W;

  // out_tdata: status, data_out, dropped_oldest, used_count, free_count, is_empty
  localparam int OUT_STATUS_LSB  = 0;
  localparam int OUT_DATA_LSB    = 1;
  localparam int OUT_DROP_LSB    = OUT_DATA_LSB + DATA_W;
  localparam int OUT_USED_LSB    = OUT_DROP_LSB + 1;
  localparam int OUT_FREE_LSB    = OUT_USED_LSB + CNT_W;
  localparam int OUT_EMPTY_LSB   = OUT_FREE_LSB + CNT_W;
  localparam int OUT_BITS        = OUT_EMPTY_LSB + 1;
  localparam int OUT_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_CLR  = 2'd3
  } op_t;

  // Out-of-range lengths act as the nearest legal value.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] res;
    if (int'(v) < 2) res = LEN_W'(2);
    else if (int'(v) > DEPTH) res = LEN_W'(DEPTH);
    else res = LEN_W'(v);
    return res;
  endfunction

  // Step a ring index, wrapping by compare.
  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] idx,
                                           input logic [LEN_W-1:0] len);
    logic [LEN_W:0] inc;
    inc = {1'b0, LEN_W'(idx)} + (LEN_W+1)'(1);
    return (inc >= {1'b0, len}) ? '0 : PTR_W'(inc);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rfo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the ring slots.
`default_nettype none
module rfo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/ring_fifo_overwrite_peek.sv =====
// Result: registered at the execute edge, after the request is captured at the input transfer.
// Requests: a new request is taken only while idle, once the previous one has executed; the
//   slot RAM's registered read sets the execute cycle, which also waits while a previous result is not yet taken.
// Reset (synchronous, rst_n low): indices zero, length 16, no result pending.
//   Slot contents are not cleared; a length write also empties the FIFO.
// Depends on rfo_pkg and rfo_ram.
`default_nettype none
module ring_fifo_overwrite_peek (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration: length_in_use
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rfo_pkg::CFG_W-1:0]          cfg_data,
  // requests
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [rfo_pkg::IN_TDATA_W-1:0]     in_tdata,  // data_in, force_req, zero pad
  input  wire logic [rfo_pkg::OP_W-1:0]           in_tuser,  // func
  // results
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [rfo_pkg::OUT_TDATA_W-1:0]         out_tdata  // status, data_out,
                                                             // dropped_oldest, used_count,
                                                             // free_count, is_empty, zero pad
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                              state_r, state_nxt;
  logic [rfo_pkg::PTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [rfo_pkg::PTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [rfo_pkg::LEN_W-1:0]           len_r, len_nxt;
  logic                                out_tvalid_r, out_tvalid_nxt;
  logic [rfo_pkg::OUT_TDATA_W-1:0]     out_tdata_r, out_tdata_nxt;
  rfo_pkg::op_t                        op_r;
  logic [rfo_pkg::ELEM_BITS-1:0]       din_r;
  logic                                force_r;

  logic                                in_xfer, fire;
  logic                                ram_we;
  logic [rfo_pkg::ELEM_BITS-1:0]       ram_rdata;
  logic [rfo_pkg::PTR_W-1:0]           wr_adv;
  logic                                status;
  logic                                dropped;
  logic [rfo_pkg::DATA_W-1:0]          dout;
  logic [rfo_pkg::LEN_W-1:0]           used_full;
  logic [rfo_pkg::CNT_W-1:0]           used, freec;
  logic                                empty;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign fire       = (state_r == S_EXEC) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign wr_adv     = rfo_pkg::adv(wr_ptr_r, len_r);

  rfo_ram #(
    .WIDTH (rfo_pkg::ELEM_BITS),
    .DEPTH (rfo_pkg::DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (din_r),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    len_nxt    = len_r;
    status     = 1'b0;
    dropped    = 1'b0;
    dout       = '0;
    ram_we     = 1'b0;

    case (op_r)
      rfo_pkg::OP_ENQ: begin
        if (wr_adv == rd_ptr_r && !force_r) begin
          status = 1'b1;
        end else begin
          if (wr_adv == rd_ptr_r) begin
            rd_ptr_nxt = rfo_pkg::adv(rd_ptr_r, len_r);
            dropped    = 1'b1;
          end
          wr_ptr_nxt = wr_adv;
          ram_we     = fire;
        end
      end
      rfo_pkg::OP_DEQ, rfo_pkg::OP_PEEK: begin
        if (wr_ptr_r == rd_ptr_r) begin
          status = 1'b1;
        end else begin
          dout = rfo_pkg::DATA_W'(ram_rdata);
          if (op_r == rfo_pkg::OP_DEQ) begin
            rd_ptr_nxt = rfo_pkg::adv(rd_ptr_r, len_r);
          end
        end
      end
      default: begin
        wr_ptr_nxt = '0;
        rd_ptr_nxt = '0;
      end
    endcase

    // counts after the request
    if (wr_ptr_nxt >= rd_ptr_nxt) begin
      used_full = rfo_pkg::LEN_W'(wr_ptr_nxt) - rfo_pkg::LEN_W'(rd_ptr_nxt);
    end else begin
      used_full = rfo_pkg::LEN_W'(wr_ptr_nxt) + len_r - rfo_pkg::LEN_W'(rd_ptr_nxt);
    end
    used  = used_full[rfo_pkg::CNT_W-1:0];
    freec = rfo_pkg::CNT_W'(len_r - rfo_pkg::LEN_W'(1) - used_full);
    empty = (wr_ptr_nxt == rd_ptr_nxt);

    out_tdata_nxt = {(rfo_pkg::OUT_TDATA_W - rfo_pkg::OUT_BITS)'(0),
                     empty, freec, used, dropped, dout, status};

    if (!fire) begin
      wr_ptr_nxt = wr_ptr_r;
      rd_ptr_nxt = rd_ptr_r;
    end

    // length write empties the FIFO; the user must write it only while idle, as the block does not enforce this
    if (cfg_valid) begin
      len_nxt    = rfo_pkg::clamp_len(cfg_data);
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
    end

    case (state_r)
      S_IDLE:  state_nxt = in_xfer ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = fire ? S_IDLE : S_EXEC;
      default: state_nxt = S_IDLE;
    endcase

    if (fire) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      len_r        <= rfo_pkg::LEN_W'(rfo_pkg::DEPTH);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      len_r        <= len_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (fire) begin
        out_tdata_r <= out_tdata_nxt;
      end
      if (in_xfer) begin
        op_r    <= rfo_pkg::op_t'(in_tuser);
        din_r   <= rfo_pkg::ELEM_BITS'(in_tdata[rfo_pkg::DATA_W-1:0]);
        force_r <= in_tdata[rfo_pkg::IN_FORCE_LSB];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rfo_checker.sv =====
// Port-level checks on the result stream of ring_fifo_overwrite_peek, and the bind.
// Depends on rfo_pkg for the result field positions.
`default_nettype none
module rfo_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [rfo_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                         status, dropped, empty;
  logic [rfo_pkg::DATA_W-1:0]   dout;
  logic [rfo_pkg::CNT_W-1:0]    used, freec;
  logic [rfo_pkg::CNT_W:0]      total;

  assign status  = out_tdata[rfo_pkg::OUT_STATUS_LSB];
  assign dropped = out_tdata[rfo_pkg::OUT_DROP_LSB];
  assign empty   = out_tdata[rfo_pkg::OUT_EMPTY_LSB];
  assign dout    = out_tdata[rfo_pkg::OUT_DATA_LSB +: rfo_pkg::DATA_W];
  assign used    = out_tdata[rfo_pkg::OUT_USED_LSB +: rfo_pkg::CNT_W];
  assign freec   = out_tdata[rfo_pkg::OUT_FREE_LSB +: rfo_pkg::CNT_W];
  assign total   = {1'b0, used} + {1'b0, freec};

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (empty == (used == '0)))
    else $error("is_empty disagrees with used_count");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> total <= (rfo_pkg::CNT_W+1)'(rfo_pkg::DEPTH - 1))
    else $error("used plus free exceeds capacity");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && dropped |-> !status && !empty)
    else $error("overwrite reported on a rejected request");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status |-> dout == '0)
    else $error("rejected request returned data");

endmodule

bind ring_fifo_overwrite_peek rfo_checker u_rfo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
